### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define RSI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, quiet during reset
`define RSI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// next-cycle implication that also holds across reset
`define RSI_ASSERT_NXT_NORST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("reset check failed");

`endif

### hdl/rsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// shared constants, register codes and pipeline step functions
// ----------------------------------------------------------------------------
package rsi_pkg;

   // configuration port
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   typedef enum logic [2:0] {
      REG_CENTER_X  = 3'd0,
      REG_CENTER_Y  = 3'd1,
      REG_CENTER_Z  = 3'd2,
      REG_RADIUS_SQ = 3'd3,
      REG_SPHERE_ID = 3'd4
   } csr_index_type;

   // square root pipeline: radicand and root widths
   localparam int SQ_RW = 70;
   localparam int SQ_QW = SQ_RW / 2;

   // divider pipeline: numerator, divisor and quotient widths
   localparam int DV_NW = 46;
   localparam int DV_DW = 31;
   localparam int DV_QW = 16;
   localparam int DV_BW = $clog2(DV_QW);

   typedef struct packed {
      logic [SQ_RW-1:0] x;
      logic [SQ_QW+1:0] r;
      logic [SQ_QW-1:0] q;
   } sq_stage_type;

   typedef struct packed {
      logic [DV_NW-1:0] rem;
      logic [DV_QW-1:0] q;
      logic [DV_DW-1:0] den;
   } dv_stage_type;

   // one root bit per step, restoring
   function automatic sq_stage_type sqrt_step(sq_stage_type s);
      logic [SQ_QW+3:0] rs;
      logic [SQ_QW+3:0] trial;
      logic [SQ_QW+3:0] diff;
      sq_stage_type     n;
      rs    = {s.r, s.x[SQ_RW-1 -: 2]};
      trial = {2'b00, s.q, 2'b01};
      diff  = rs - trial;
      n.x   = {s.x[SQ_RW-3:0], 2'b00};
      if (rs >= trial) begin
         n.r = diff[SQ_QW+1:0];
         n.q = {s.q[SQ_QW-2:0], 1'b1};
      end else begin
         n.r = rs[SQ_QW+1:0];
         n.q = {s.q[SQ_QW-2:0], 1'b0};
      end
      return n;
   endfunction

   // one quotient bit per step, restoring
   function automatic dv_stage_type div_step(dv_stage_type s, logic [DV_BW-1:0] bitpos);
      logic [DV_NW:0] shifted;
      dv_stage_type   n;
      shifted = {{(DV_NW + 1 - DV_DW){1'b0}}, s.den} << bitpos;
      n = s;
      if ({1'b0, s.rem} >= shifted) begin
         n.rem = s.rem - shifted[DV_NW-1:0];
         n.q[bitpos] = 1'b1;
      end
      return n;
   endfunction

endpackage

### hdl/rsi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_req_if / rsi_rsp_if
// ray word and intersection word channels, valid/ready
// ----------------------------------------------------------------------------
interface rsi_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   output ready);
endinterface

interface rsi_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic [30:0]        hit_distance;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic [15:0]        object_id;

   modport source (output valid, hit, hit_distance, normal_x, normal_y, normal_z,
                   object_id, input ready);
   modport sink   (input valid, hit, hit_distance, normal_x, normal_y, normal_z,
                   object_id, output ready);
endinterface

### hdl/rsi_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_sqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module rsi_sqrt (
   input  logic                      clock,
   input  logic                      en,
   input  logic [rsi_pkg::SQ_RW-1:0] radicand,
   output logic [rsi_pkg::SQ_QW-1:0] root
);

   rsi_pkg::sq_stage_type st_ff [rsi_pkg::SQ_QW];
   rsi_pkg::sq_stage_type st_in [rsi_pkg::SQ_QW];
   rsi_pkg::sq_stage_type first;

   always_comb begin
      first.x = radicand;
      first.r = '0;
      first.q = '0;
      st_in[0] = rsi_pkg::sqrt_step(first);
      for (int k = 1; k < rsi_pkg::SQ_QW; k++) begin
         st_in[k] = rsi_pkg::sqrt_step(st_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < rsi_pkg::SQ_QW; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign root = st_ff[rsi_pkg::SQ_QW-1].q;

endmodule

### hdl/rsi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_div
// pipelined unsigned divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rsi_div (
   input  logic                      clock,
   input  logic                      en,
   input  logic [rsi_pkg::DV_NW-1:0] num,
   input  logic [rsi_pkg::DV_DW-1:0] den,
   output logic [rsi_pkg::DV_QW-1:0] quot
);

   rsi_pkg::dv_stage_type st_ff [rsi_pkg::DV_QW];
   rsi_pkg::dv_stage_type st_in [rsi_pkg::DV_QW];
   rsi_pkg::dv_stage_type first;

   always_comb begin
      first.rem = num;
      first.q   = '0;
      first.den = den;
      st_in[0] = rsi_pkg::div_step(first, rsi_pkg::DV_BW'(rsi_pkg::DV_QW - 1));
      for (int k = 1; k < rsi_pkg::DV_QW; k++) begin
         st_in[k] = rsi_pkg::div_step(st_ff[k-1], rsi_pkg::DV_BW'(rsi_pkg::DV_QW - 1 - k));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < rsi_pkg::DV_QW; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign quot = st_ff[rsi_pkg::DV_QW-1].q;

endmodule

### hdl/ray_sphere_intersection_unit.sv
// throughput: one ray per cycle unless stalled; two 35-stage root pipelines
//    and a 16-stage divider set the depth, every stage holds one ray
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset (synchronous, active high) clears all valid bits and the CSRs
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersection_unit
// geometric ray / sphere test: distance to nearer non-negative root and
// unit surface normal, fully pipelined
// ----------------------------------------------------------------------------
module ray_sphere_intersection_unit (
   input  logic                       clock,
   input  logic                       reset,
   rsi_req_if.sink                    req_chan,
   rsi_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rsi_pkg::CSR_AW-1:0] paddr,
   input  logic [rsi_pkg::CSR_DW-1:0] pwdata,
   output logic [rsi_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);

   localparam int QW = rsi_pkg::SQ_QW;
   localparam int DQ = rsi_pkg::DV_QW;

   // ---------------------------------------------------------------------
   // configuration registers, 8-byte spacing
   // ---------------------------------------------------------------------
   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [62:0]        radius_sq_ff;
   logic [15:0]        sphere_id_ff;
   logic [2:0]         csr_idx;
   logic               csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[rsi_pkg::CSR_AW-1:3];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         center_z_ff  <= '0;
         radius_sq_ff <= '0;
         sphere_id_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            rsi_pkg::REG_CENTER_X:  center_x_ff  <= pwdata[31:0];
            rsi_pkg::REG_CENTER_Y:  center_y_ff  <= pwdata[31:0];
            rsi_pkg::REG_CENTER_Z:  center_z_ff  <= pwdata[31:0];
            rsi_pkg::REG_RADIUS_SQ: radius_sq_ff <= pwdata[62:0];
            rsi_pkg::REG_SPHERE_ID: sphere_id_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         rsi_pkg::REG_CENTER_X:  prdata = {{32{center_x_ff[31]}}, center_x_ff};
         rsi_pkg::REG_CENTER_Y:  prdata = {{32{center_y_ff[31]}}, center_y_ff};
         rsi_pkg::REG_CENTER_Z:  prdata = {{32{center_z_ff[31]}}, center_z_ff};
         rsi_pkg::REG_RADIUS_SQ: prdata = {1'b0, radius_sq_ff};
         rsi_pkg::REG_SPHERE_ID: prdata = {48'd0, sphere_id_ff};
         default:                prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // global advance: everything moves unless the output word is held
   // ---------------------------------------------------------------------
   logic o_v_ff;
   logic adv;

   assign adv            = !o_v_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // ---------------------------------------------------------------------
   // stage a: L = center - origin, exact 33 bits
   // ---------------------------------------------------------------------
   logic signed [31:0] org [3];
   logic signed [31:0] cen [3];
   logic signed [15:0] dir [3];
   logic signed [32:0] a_l_in [3];
   logic signed [32:0] a_l_ff [3];
   logic signed [15:0] a_d_ff [3];
   logic               a_v_ff;

   always_comb begin
      org[0] = req_chan.origin_x;
      org[1] = req_chan.origin_y;
      org[2] = req_chan.origin_z;
      dir[0] = req_chan.dir_x;
      dir[1] = req_chan.dir_y;
      dir[2] = req_chan.dir_z;
      cen[0] = center_x_ff;
      cen[1] = center_y_ff;
      cen[2] = center_z_ff;
      for (int i = 0; i < 3; i++) begin
         a_l_in[i] = {cen[i][31], cen[i]} - {org[i][31], org[i]};
      end
   end

   // ---------------------------------------------------------------------
   // stage b: L*D terms and L*L terms
   // ---------------------------------------------------------------------
   logic [32:0]        a_mag [3];
   logic signed [48:0] b_ld_in [3];
   logic [65:0]        b_sq_in [3];
   logic signed [48:0] b_ld_ff [3];
   logic [65:0]        b_sq_ff [3];
   logic signed [32:0] b_l_ff [3];
   logic signed [15:0] b_d_ff [3];
   logic               b_v_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_mag[i]   = a_l_ff[i][32] ? 33'(-a_l_ff[i]) : a_l_ff[i];
         b_ld_in[i] = a_l_ff[i] * a_d_ff[i];
         b_sq_in[i] = 66'(a_mag[i]) * 66'(a_mag[i]);
      end
   end

   // ---------------------------------------------------------------------
   // stage c: tca rounded to Q.0 (integer), L.L sum
   // ---------------------------------------------------------------------
   logic signed [50:0] c_tex;
   logic signed [50:0] c_tsh;
   logic signed [34:0] c_t_in;
   logic [67:0]        c_ll_in;
   logic signed [34:0] c_t_ff;
   logic [67:0]        c_ll_ff;
   logic signed [32:0] c_l_ff [3];
   logic signed [15:0] c_d_ff [3];
   logic               c_v_ff;

   always_comb begin
      c_tex   = 51'(b_ld_ff[0]) + 51'(b_ld_ff[1]) + 51'(b_ld_ff[2]) + 51'sd16384;
      c_tsh   = c_tex >>> 15;
      c_t_in  = c_tsh[34:0];
      c_ll_in = 68'(b_sq_ff[0]) + 68'(b_sq_ff[1]) + 68'(b_sq_ff[2]);
   end

   // ---------------------------------------------------------------------
   // stage e: tca squared
   // ---------------------------------------------------------------------
   logic [33:0]        e_tmag;
   logic [67:0]        e_t2_in;
   logic [67:0]        e_t2_ff;
   logic [67:0]        e_ll_ff;
   logic signed [34:0] e_t_ff;
   logic signed [32:0] e_l_ff [3];
   logic signed [15:0] e_d_ff [3];
   logic               e_v_ff;

   always_comb begin
      e_tmag  = c_t_ff[34] ? 34'(-c_t_ff) : c_t_ff[33:0];
      e_t2_in = 68'(e_tmag) * 68'(e_tmag);
   end

   // ---------------------------------------------------------------------
   // stage f: miss test L.L > tca^2 + r2, radicand for thc
   // ---------------------------------------------------------------------
   logic [68:0]        f_rhs;
   logic               f_miss_in;
   logic [68:0]        f_diff_in;
   logic               f_miss_ff;
   logic [68:0]        f_diff_ff;
   logic signed [34:0] f_t_ff;
   logic signed [32:0] f_l_ff [3];
   logic signed [15:0] f_d_ff [3];
   logic               f_v_ff;

   always_comb begin
      f_rhs     = 69'(e_t2_ff) + 69'(radius_sq_ff);
      f_miss_in = 69'(e_ll_ff) > f_rhs;
      f_diff_in = f_rhs - 69'(e_ll_ff);
   end

   // ---------------------------------------------------------------------
   // thc = floor(sqrt(r2 + tca^2 - L.L)), side data rides alongside
   // ---------------------------------------------------------------------
   logic [QW-1:0]      thc;
   logic               s1_v_ff    [QW];
   logic               s1_miss_ff [QW];
   logic signed [34:0] s1_t_ff    [QW];
   logic signed [32:0] s1_l_ff    [QW][3];
   logic signed [15:0] s1_d_ff    [QW][3];

   rsi_sqrt u_sqrt_thc (
      .clock    (clock),
      .en       (adv),
      .radicand ({1'b0, f_diff_ff}),
      .root     (thc)
   );

   // ---------------------------------------------------------------------
   // stage g: pick nearer non-negative root, saturate distance
   // ---------------------------------------------------------------------
   logic signed [36:0] g_te, g_th, g_t0, g_t1, g_ts;
   logic               g_hit_in;
   logic [35:0]        g_ts_in;
   logic [30:0]        g_dist_in;
   logic               g_hit_ff;
   logic [35:0]        g_ts_ff;
   logic [30:0]        g_dist_ff;
   logic signed [32:0] g_l_ff [3];
   logic signed [15:0] g_d_ff [3];
   logic               g_v_ff;

   always_comb begin
      g_te      = 37'(s1_t_ff[QW-1]);
      g_th      = $signed({2'b00, thc});
      g_t0      = g_te - g_th;
      g_t1      = g_te + g_th;
      g_hit_in  = !s1_miss_ff[QW-1] && (!g_t0[36] || !g_t1[36]);
      g_ts      = !g_t0[36] ? g_t0 : g_t1;
      g_ts_in   = g_ts[35:0];
      g_dist_in = (g_ts[35:31] != 5'd0) ? 31'h7FFF_FFFF : g_ts[30:0];
   end

   // ---------------------------------------------------------------------
   // stage h: N = t*D - L, exact Q.15, split into sign and magnitude
   // ---------------------------------------------------------------------
   logic signed [53:0] h_prod [3];
   logic signed [53:0] h_c    [3];
   logic               h_sg_in [3];
   logic [53:0]        h_m_in  [3];
   logic               h_sg_ff [3];
   logic [53:0]        h_m_ff  [3];
   logic               h_hit_ff;
   logic [30:0]        h_dist_ff;
   logic               h_v_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         h_prod[i]  = $signed({1'b0, g_ts_ff}) * g_d_ff[i];
         h_c[i]     = h_prod[i] - 54'($signed({g_l_ff[i], 15'd0}));
         h_sg_in[i] = h_c[i][53];
         h_m_in[i]  = h_c[i][53] ? 54'(-h_c[i]) : h_c[i];
      end
   end

   // ---------------------------------------------------------------------
   // stage i: common shift so the largest magnitude drops below 2^30
   // ---------------------------------------------------------------------
   logic [53:0] i_or;
   logic [23:0] i_therm;
   logic [4:0]  i_s_in;
   logic [4:0]  i_s_ff;
   logic [53:0] i_m_ff [3];
   logic        i_sg_ff [3];
   logic        i_hit_ff;
   logic [30:0] i_dist_ff;
   logic        i_v_ff;

   always_comb begin
      i_or = h_m_ff[0] | h_m_ff[1] | h_m_ff[2];
      // one threshold per possible shift, summed as a thermometer code
      for (int j = 0; j < 24; j++) begin
         i_therm[j] = |(i_or >> (30 + j));
      end
      i_s_in = 5'($countones(i_therm));
   end

   // ---------------------------------------------------------------------
   // stage j: apply the shift
   // ---------------------------------------------------------------------
   logic [53:0] j_sh [3];
   logic [29:0] j_mn_in [3];
   logic [29:0] j_mn_ff [3];
   logic        j_sg_ff [3];
   logic        j_hit_ff;
   logic [30:0] j_dist_ff;
   logic        j_v_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         j_sh[i]    = i_m_ff[i] >> i_s_ff;
         j_mn_in[i] = j_sh[i][29:0];
      end
   end

   // ---------------------------------------------------------------------
   // stage k: squares; stage l: sum of squares
   // ---------------------------------------------------------------------
   logic [59:0] k_sq_in [3];
   logic [59:0] k_sq_ff [3];
   logic [29:0] k_mn_ff [3];
   logic        k_sg_ff [3];
   logic        k_hit_ff;
   logic [30:0] k_dist_ff;
   logic        k_v_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         k_sq_in[i] = 60'(j_mn_ff[i]) * 60'(j_mn_ff[i]);
      end
   end

   logic [61:0] l_ss_in;
   logic [61:0] l_ss_ff;
   logic [29:0] l_mn_ff [3];
   logic        l_sg_ff [3];
   logic        l_hit_ff;
   logic [30:0] l_dist_ff;
   logic        l_v_ff;

   assign l_ss_in = 62'(k_sq_ff[0]) + 62'(k_sq_ff[1]) + 62'(k_sq_ff[2]);

   // ---------------------------------------------------------------------
   // len = floor(sqrt(sum of squares))
   // ---------------------------------------------------------------------
   logic [QW-1:0] len_root;
   logic [30:0]   len;
   logic          s2_v_ff    [QW];
   logic          s2_hit_ff  [QW];
   logic [30:0]   s2_dist_ff [QW];
   logic          s2_sg_ff   [QW][3];
   logic [29:0]   s2_mn_ff   [QW][3];

   rsi_sqrt u_sqrt_len (
      .clock    (clock),
      .en       (adv),
      .radicand ({{(rsi_pkg::SQ_RW - 62){1'b0}}, l_ss_ff}),
      .root     (len_root)
   );

   assign len = len_root[30:0];

   // ---------------------------------------------------------------------
   // normal components: round(m * 32768 / len), half up
   // ---------------------------------------------------------------------
   logic [rsi_pkg::DV_NW-1:0] dv_num [3];
   logic [DQ-1:0]             dv_q   [3];
   logic                      s3_v_ff    [DQ];
   logic                      s3_hit_ff  [DQ];
   logic                      s3_zlen_ff [DQ];
   logic [30:0]               s3_dist_ff [DQ];
   logic                      s3_sg_ff   [DQ][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv_num[i] = {1'b0, s2_mn_ff[QW-1][i], 15'd0} + rsi_pkg::DV_NW'(len[30:1]);
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_div
      rsi_div u_div (
         .clock (clock),
         .en    (adv),
         .num   (dv_num[g]),
         .den   (len),
         .quot  (dv_q[g])
      );
   end

   // ---------------------------------------------------------------------
   // output stage: clamp, apply sign, zero on miss or zero length
   // ---------------------------------------------------------------------
   logic [15:0]        o_qc  [3];
   logic signed [15:0] o_n   [3];
   logic [16:0]        o_neg [3];
   logic               o_hit_ff;
   logic [30:0]        o_dist_ff;
   logic signed [15:0] o_n_ff [3];
   logic [15:0]        o_id_ff;
   logic               o_nrm_ok;

   always_comb begin
      o_nrm_ok = s3_hit_ff[DQ-1] && !s3_zlen_ff[DQ-1];
      for (int i = 0; i < 3; i++) begin
         o_qc[i]  = (dv_q[i] > 16'd32768) ? 16'd32768 : dv_q[i];
         o_neg[i] = 17'd0 - {1'b0, o_qc[i]};
         if (s3_sg_ff[DQ-1][i]) begin
            o_n[i] = o_neg[i][15:0];
         end else begin
            o_n[i] = (o_qc[i] > 16'd32767) ? 16'sh7FFF : o_qc[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // valid bits, cleared by reset
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
         i_v_ff <= 1'b0;
         j_v_ff <= 1'b0;
         k_v_ff <= 1'b0;
         l_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
         for (int k = 0; k < QW; k++) begin
            s1_v_ff[k] <= 1'b0;
            s2_v_ff[k] <= 1'b0;
         end
         for (int k = 0; k < DQ; k++) begin
            s3_v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         a_v_ff <= req_chan.valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         e_v_ff <= c_v_ff;
         f_v_ff <= e_v_ff;
         s1_v_ff[0] <= f_v_ff;
         for (int k = 1; k < QW; k++) begin
            s1_v_ff[k] <= s1_v_ff[k-1];
         end
         g_v_ff <= s1_v_ff[QW-1];
         h_v_ff <= g_v_ff;
         i_v_ff <= h_v_ff;
         j_v_ff <= i_v_ff;
         k_v_ff <= j_v_ff;
         l_v_ff <= k_v_ff;
         s2_v_ff[0] <= l_v_ff;
         for (int k = 1; k < QW; k++) begin
            s2_v_ff[k] <= s2_v_ff[k-1];
         end
         s3_v_ff[0] <= s2_v_ff[QW-1];
         for (int k = 1; k < DQ; k++) begin
            s3_v_ff[k] <= s3_v_ff[k-1];
         end
         o_v_ff <= s3_v_ff[DQ-1];
      end
   end

   // ---------------------------------------------------------------------
   // payload registers, no reset
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            a_l_ff[i]  <= a_l_in[i];
            a_d_ff[i]  <= dir[i];
            b_ld_ff[i] <= b_ld_in[i];
            b_sq_ff[i] <= b_sq_in[i];
            b_l_ff[i]  <= a_l_ff[i];
            b_d_ff[i]  <= a_d_ff[i];
            c_l_ff[i]  <= b_l_ff[i];
            c_d_ff[i]  <= b_d_ff[i];
            e_l_ff[i]  <= c_l_ff[i];
            e_d_ff[i]  <= c_d_ff[i];
            f_l_ff[i]  <= e_l_ff[i];
            f_d_ff[i]  <= e_d_ff[i];
            s1_l_ff[0][i] <= f_l_ff[i];
            s1_d_ff[0][i] <= f_d_ff[i];
            for (int k = 1; k < QW; k++) begin
               s1_l_ff[k][i] <= s1_l_ff[k-1][i];
               s1_d_ff[k][i] <= s1_d_ff[k-1][i];
            end
            g_l_ff[i]  <= s1_l_ff[QW-1][i];
            g_d_ff[i]  <= s1_d_ff[QW-1][i];
            h_sg_ff[i] <= h_sg_in[i];
            h_m_ff[i]  <= h_m_in[i];
            i_m_ff[i]  <= h_m_ff[i];
            i_sg_ff[i] <= h_sg_ff[i];
            j_mn_ff[i] <= j_mn_in[i];
            j_sg_ff[i] <= i_sg_ff[i];
            k_sq_ff[i] <= k_sq_in[i];
            k_mn_ff[i] <= j_mn_ff[i];
            k_sg_ff[i] <= j_sg_ff[i];
            l_mn_ff[i] <= k_mn_ff[i];
            l_sg_ff[i] <= k_sg_ff[i];
            s2_mn_ff[0][i] <= l_mn_ff[i];
            s2_sg_ff[0][i] <= l_sg_ff[i];
            for (int k = 1; k < QW; k++) begin
               s2_mn_ff[k][i] <= s2_mn_ff[k-1][i];
               s2_sg_ff[k][i] <= s2_sg_ff[k-1][i];
            end
            s3_sg_ff[0][i] <= s2_sg_ff[QW-1][i];
            for (int k = 1; k < DQ; k++) begin
               s3_sg_ff[k][i] <= s3_sg_ff[k-1][i];
            end
            o_n_ff[i] <= o_nrm_ok ? o_n[i] : 16'sd0;
         end

         c_t_ff  <= c_t_in;
         c_ll_ff <= c_ll_in;
         e_t_ff  <= c_t_ff;
         e_ll_ff <= c_ll_ff;
         e_t2_ff <= e_t2_in;
         f_t_ff    <= e_t_ff;
         f_miss_ff <= f_miss_in;
         f_diff_ff <= f_diff_in;

         s1_t_ff[0]    <= f_t_ff;
         s1_miss_ff[0] <= f_miss_ff;
         for (int k = 1; k < QW; k++) begin
            s1_t_ff[k]    <= s1_t_ff[k-1];
            s1_miss_ff[k] <= s1_miss_ff[k-1];
         end

         g_hit_ff  <= g_hit_in;
         g_ts_ff   <= g_ts_in;
         g_dist_ff <= g_dist_in;
         h_hit_ff  <= g_hit_ff;
         h_dist_ff <= g_dist_ff;
         i_s_ff    <= i_s_in;
         i_hit_ff  <= h_hit_ff;
         i_dist_ff <= h_dist_ff;
         j_hit_ff  <= i_hit_ff;
         j_dist_ff <= i_dist_ff;
         k_hit_ff  <= j_hit_ff;
         k_dist_ff <= j_dist_ff;
         l_ss_ff   <= l_ss_in;
         l_hit_ff  <= k_hit_ff;
         l_dist_ff <= k_dist_ff;

         s2_hit_ff[0]  <= l_hit_ff;
         s2_dist_ff[0] <= l_dist_ff;
         for (int k = 1; k < QW; k++) begin
            s2_hit_ff[k]  <= s2_hit_ff[k-1];
            s2_dist_ff[k] <= s2_dist_ff[k-1];
         end

         s3_hit_ff[0]  <= s2_hit_ff[QW-1];
         s3_dist_ff[0] <= s2_dist_ff[QW-1];
         s3_zlen_ff[0] <= (len == 31'd0);
         for (int k = 1; k < DQ; k++) begin
            s3_hit_ff[k]  <= s3_hit_ff[k-1];
            s3_dist_ff[k] <= s3_dist_ff[k-1];
            s3_zlen_ff[k] <= s3_zlen_ff[k-1];
         end

         o_hit_ff  <= s3_hit_ff[DQ-1];
         o_dist_ff <= s3_hit_ff[DQ-1] ? s3_dist_ff[DQ-1] : 31'd0;
         o_id_ff   <= s3_hit_ff[DQ-1] ? sphere_id_ff : 16'd0;
      end
   end

   // result word
   assign rsp_chan.valid        = o_v_ff;
   assign rsp_chan.hit          = o_hit_ff;
   assign rsp_chan.hit_distance = o_dist_ff;
   assign rsp_chan.normal_x     = o_n_ff[0];
   assign rsp_chan.normal_y     = o_n_ff[1];
   assign rsp_chan.normal_z     = o_n_ff[2];
   assign rsp_chan.object_id    = o_id_ff;

endmodule

### hdl/rsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_checker
// port-level checks on the intersection unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic [30:0]        rsp_hit_distance,
   input logic signed [15:0] rsp_normal_x,
   input logic signed [15:0] rsp_normal_y,
   input logic signed [15:0] rsp_normal_z,
   input logic [15:0]        rsp_object_id
);

   // no result word right after reset
   `RSI_ASSERT_NXT_NORST(a_reset_empty, clock, reset, !rsp_valid)

   // a held result word blocks the input side
   `RSI_ASSERT_IMP(a_backpressure, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // a miss word is all zero
   `RSI_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_hit_distance == 31'd0 && rsp_object_id == 16'd0 && rsp_normal_x == 16'sd0 && rsp_normal_y == 16'sd0 && rsp_normal_z == 16'sd0)

   // a stalled word stays put: valid, hit, distance and object id
   `RSI_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_hit_distance) && $stable(rsp_object_id))

endmodule

bind ray_sphere_intersection_unit rsi_checker u_rsi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_hit          (rsp_chan.hit),
   .rsp_hit_distance (rsp_chan.hit_distance),
   .rsp_normal_x     (rsp_chan.normal_x),
   .rsp_normal_y     (rsp_chan.normal_y),
   .rsp_normal_z     (rsp_chan.normal_z),
   .rsp_object_id    (rsp_chan.object_id)
);
